// ===== hdl/scar_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stereo comb/allpass reverb.
// Depends on nothing; used by scar_lane, scar_merge and the top level.
package scar_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int NUM_COMBS    = 8;
	localparam int NUM_APS      = 4;
	localparam int COMB_DEPTH   = 11208;   // right channel total, left fits below
	localparam int AP_DEPTH     = 1655;
	localparam int COMB_AW      = $clog2(COMB_DEPTH);
	localparam int AP_AW        = $clog2(AP_DEPTH);
	localparam int ACC_W        = 40;      // comb sum and allpass chain width

	localparam logic [1:0] REG_ROOM = 2'd0;
	localparam logic [1:0] REG_DAMP = 2'd1;
	localparam logic [1:0] REG_WET  = 2'd2;

	// line lengths and base offsets, [channel][line]
	localparam logic [10:0] COMB_SIZE [2][NUM_COMBS] = '{
		'{11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617},
		'{11'd1139, 11'd1211, 11'd1300, 11'd1379, 11'd1445, 11'd1514, 11'd1580, 11'd1640}};
	localparam logic [13:0] COMB_OFF [2][NUM_COMBS] = '{
		'{14'd0, 14'd1116, 14'd2304, 14'd3581, 14'd4937, 14'd6359, 14'd7850, 14'd9407},
		'{14'd0, 14'd1139, 14'd2350, 14'd3650, 14'd5029, 14'd6474, 14'd7988, 14'd9568}};
	localparam logic [9:0] AP_LEN [2][NUM_APS] = '{
		'{10'd556, 10'd441, 10'd341, 10'd225},
		'{10'd579, 10'd464, 10'd364, 10'd248}};
	localparam logic [10:0] AP_OFF [2][NUM_APS] = '{
		'{11'd0, 11'd556, 11'd997, 11'd1338},
		'{11'd0, 11'd579, 11'd1043, 11'd1407}};

	typedef enum logic [3:0] {
		L_CLR, L_IDLE, C_RD, C_MUL, C_LP, C_FB, C_WR, A_RD, A_WR
	} lane_state_t;

	typedef enum logic [2:0] {
		T_IDLE, T_RUN, T_MUL, T_SUM, T_PUT
	} top_state_t;

	// per-frame coefficients handed to each lane
	typedef struct packed {
		logic               start;
		logic signed [23:0] mono;
		logic [15:0]        fb;
		logic [16:0]        d1;
		logic [16:0]        d2;
	} lane_ctl_t;

	typedef struct packed {
		logic ready;
		logic done;
	} lane_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic [16:0] clamp_q16(input logic [16:0] v);
		return (v > 17'd65536) ? 17'd65536 : v;
	endfunction

endpackage

// ===== hdl/scar_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/scar_lane.sv =====
// One channel of the reverb: eight damped comb lines and four serial allpasses.
// Uses scar_pkg and two scar_ram instances; clears its lines after reset.
module scar_lane
	import scar_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    chan,
	input  lane_ctl_t               ctl,
	output lane_stat_t              stat,
	output logic signed [ACC_W-1:0] acc
);

	lane_state_t state_q, state_d;
	logic [COMB_AW-1:0] cnt_q;
	logic [2:0]  idx_q;
	logic [10:0] cpos_q [NUM_COMBS];
	logic [9:0]  apos_q [NUM_APS];
	logic signed [31:0] lp_q [NUM_COMBS];
	logic signed [31:0] lpn_q;
	logic signed [49:0] pa_q, pb_q;
	logic signed [48:0] pc_q;
	logic signed [ACC_W-1:0] x_q;

	logic                 c_we, a_we;
	logic [COMB_AW-1:0]   c_addr, c_waddr;
	logic [AP_AW-1:0]     a_addr, a_waddr;
	logic [31:0]          c_wdata, a_wdata, c_rdata, a_rdata;
	logic [10:0]          cpos_nx;
	logic [9:0]           apos_nx;
	logic signed [31:0]   y, b;
	logic signed [50:0]   lp_sum;
	logic signed [31:0]   lp_new;
	logic signed [31:0]   comb_w, ap_w;

	assign y = $signed(c_rdata);
	assign b = $signed(a_rdata);

	// addresses of the current line position
	assign c_addr = COMB_AW'(COMB_OFF[chan][idx_q]) + COMB_AW'(cpos_q[idx_q]);
	assign a_addr = AP_AW'(AP_OFF[chan][idx_q[1:0]]) + AP_AW'(apos_q[idx_q[1:0]]);
	assign cpos_nx = (cpos_q[idx_q] + 11'd1 == COMB_SIZE[chan][idx_q]) ? 11'd0
		: cpos_q[idx_q] + 11'd1;
	assign apos_nx = (apos_q[idx_q[1:0]] + 10'd1 == AP_LEN[chan][idx_q[1:0]]) ? 10'd0
		: apos_q[idx_q[1:0]] + 10'd1;

	// comb and allpass datapath pieces
	assign lp_sum = 51'(pa_q) + 51'(pb_q) + 51'sd32768;
	assign lp_new = sat32(64'(lp_sum >>> 16));
	assign comb_w = sat32(64'(ctl.mono) + 64'((pc_q + 49'sd32768) >>> 16));
	assign ap_w   = sat32(64'(x_q) + ((64'(b) + 64'sd1) >>> 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_CLR:  if (cnt_q == COMB_AW'(COMB_DEPTH - 1)) state_d = L_IDLE;
			L_IDLE: if (ctl.start) state_d = C_RD;
			C_RD:   state_d = C_MUL;
			C_MUL:  state_d = C_LP;
			C_LP:   state_d = C_FB;
			C_FB:   state_d = C_WR;
			C_WR:   state_d = (idx_q == 3'(NUM_COMBS - 1)) ? A_RD : C_RD;
			A_RD:   state_d = A_WR;
			A_WR:   state_d = (idx_q[1:0] == 2'(NUM_APS - 1)) ? L_IDLE : A_RD;
			default: state_d = L_IDLE;
		endcase
	end

	// memory strobes and status
	always_comb begin
		c_we    = 1'b0;
		a_we    = 1'b0;
		c_waddr = c_addr;
		a_waddr = a_addr;
		c_wdata = comb_w;
		a_wdata = ap_w;
		stat.ready = 1'b0;
		stat.done  = 1'b0;
		unique case (state_q)
			L_CLR: begin
				c_we    = 1'b1;
				a_we    = (cnt_q < COMB_AW'(AP_DEPTH));
				c_waddr = cnt_q;
				a_waddr = cnt_q[AP_AW-1:0];
				c_wdata = '0;
				a_wdata = '0;
			end
			L_IDLE: stat.ready = 1'b1;
			C_WR:   c_we = 1'b1;
			A_WR: begin
				a_we      = 1'b1;
				stat.done = (idx_q[1:0] == 2'(NUM_APS - 1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_CLR;
			cnt_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < NUM_COMBS; i++) begin
				cpos_q[i] <= '0;
				lp_q[i]   <= '0;
			end
			for (int i = 0; i < NUM_APS; i++) begin
				apos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == L_CLR) cnt_q <= cnt_q + 1'b1;
			unique case (state_q)
				L_IDLE: idx_q <= '0;
				C_LP:   lp_q[idx_q] <= lp_new;
				C_WR: begin
					cpos_q[idx_q] <= cpos_nx;
					idx_q <= (idx_q == 3'(NUM_COMBS - 1)) ? 3'd0 : idx_q + 3'd1;
				end
				A_WR: begin
					apos_q[idx_q[1:0]] <= apos_nx;
					idx_q <= idx_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: if (ctl.start) x_q <= '0;
			C_MUL: begin
				pa_q <= y * $signed({1'b0, ctl.d2});
				pb_q <= lp_q[idx_q] * $signed({1'b0, ctl.d1});
				x_q  <= x_q + ACC_W'(y);
			end
			C_LP: lpn_q <= lp_new;
			C_FB: pc_q  <= lpn_q * $signed({1'b0, ctl.fb});
			A_WR: x_q   <= ACC_W'(b) - x_q;
			default: ;
		endcase
	end

	assign acc = x_q;

	scar_ram #(.WIDTH(32), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_addr), .rdata(c_rdata)
	);

	scar_ram #(.WIDTH(32), .DEPTH(AP_DEPTH)) u_ap_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_addr), .rdata(a_rdata)
	);

endmodule

// ===== hdl/scar_merge.sv =====
// Output mix: sample plus wet-scaled reverb, saturated to the sample range.
// Uses scar_pkg; two register stages, wide product split into two halves.
module scar_merge
	import scar_pkg::*;
(
	input  logic                           clk,
	input  logic signed [ACC_W-1:0]        acc,
	input  logic [16:0]                    wet,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] mixed_s2
);

	localparam int HALF = ACC_W / 2;

	logic        [HALF+16:0]   plo_s1;
	logic signed [HALF+17:0]   phi_s1;
	logic signed [ACC_W+18:0]  prod;
	logic signed [ACC_W+18:0]  sum;

	// partial products
	always_ff @(posedge clk) begin
		plo_s1 <= acc[HALF-1:0] * wet;
		phi_s1 <= $signed(acc[ACC_W-1:HALF]) * $signed({1'b0, wet});
	end

	assign prod = ((ACC_W+19)'(phi_s1) <<< HALF) + (ACC_W+19)'({1'b0, plo_s1});
	assign sum  = ((prod + (ACC_W+19)'(65536)) >>> 17) + (ACC_W+19)'(sample);

	// saturate to the sample range
	always_ff @(posedge clk) begin
		if (sum > (ACC_W+19)'(8388607))
			mixed_s2 <= 24'sh7fffff;
		else if (sum < -(ACC_W+19)'(8388608))
			mixed_s2 <= 24'sh800000;
		else
			mixed_s2 <= sum[SAMPLE_WIDTH-1:0];
	end

endmodule

// ===== hdl/stereo_comb_allpass_reverb.sv =====
// Stereo comb/allpass reverb: top level with config, frame control and output register.
// Each lane runs eight combs (read, multiply, low-pass, feedback, write) and four
// allpasses (read, write) per frame; a new frame waits until the last is registered out.
// Wet level zero passes the frame through and leaves all lines untouched.
// Reset (arst_n, async low) clears control state, then each lane sweeps its comb and allpass
// memories, during which no frame is accepted; config writes are taken as ever.
module stereo_comb_allpass_reverb
	import scar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // left_in[23:0], right_in[47:24]
	input  logic        s_tlast,   // last_in_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // left_out[23:0], right_out[47:24]
	output logic        m_tlast    // last_out
);

	top_state_t state_q, state_d;
	logic [16:0] room_q, damp_q, wet_q;
	logic [15:0] fb_q;
	logic [16:0] d1_q, d2_q;
	logic signed [23:0] mono_q;
	logic signed [SAMPLE_WIDTH-1:0] l_q, r_q, lmix, rmix;
	logic last_q, bypass_q;
	logic [16:0] wet_c, room_c, damp_c;
	logic signed [37:0] mono_full;
	logic accept, start, out_free;
	lane_ctl_t  ctl;
	lane_stat_t st_l, st_r;
	logic signed [ACC_W-1:0] acc_l, acc_r;
	logic [32:0] fb_prod, d1_prod;

	assign wet_c  = clamp_q16(wet_q);
	assign room_c = clamp_q16(room_q);
	assign damp_c = clamp_q16(damp_q);
	assign fb_prod = 33'd18350 * room_c + 33'd32768;
	assign d1_prod = 33'd26214 * damp_c + 33'd32768;

	// config registers and derived coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= 17'd32768;
			damp_q <= 17'd32768;
			wet_q  <= 17'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOM: room_q <= cfg_data;
				REG_DAMP: damp_q <= cfg_data;
				REG_WET:  wet_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fb_q <= 16'd45875 + 16'(fb_prod >> 16);
		d1_q <= 17'(d1_prod >> 16);
		d2_q <= 17'd65536 - 17'(d1_prod >> 16);
	end

	assign s_tready = (state_q == T_IDLE) && st_l.ready && st_r.ready;
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (wet_c != 17'd0);
	assign out_free = !m_tvalid || m_tready;

	// mono feed in Q23.15, in sample units
	assign mono_full = (38'(signed'(s_tdata[23:0])) + 38'(signed'(s_tdata[47:24])))
		* 38'sd2949 + 38'sd16384;

	// frame sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (accept) state_d = (wet_c == 17'd0) ? T_PUT : T_RUN;
			T_RUN:  if (st_l.done) state_d = T_MUL;
			T_MUL:  state_d = T_SUM;
			T_SUM:  state_d = T_PUT;
			T_PUT:  if (out_free) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// lane control bundle
	always_comb begin
		ctl.start = start;
		ctl.mono  = mono_q;
		ctl.fb    = fb_q;
		ctl.d1    = d1_q;
		ctl.d2    = d2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == T_PUT && out_free) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// frame and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			l_q      <= s_tdata[23:0];
			r_q      <= s_tdata[47:24];
			last_q   <= s_tlast;
			bypass_q <= (wet_c == 17'd0);
			mono_q   <= 24'(mono_full >>> 15);
		end
		if (state_q == T_PUT && out_free) begin
			m_tdata[23:0]  <= bypass_q ? l_q : lmix;
			m_tdata[47:24] <= bypass_q ? r_q : rmix;
			m_tlast        <= last_q;
		end
	end

	scar_lane u_lane_l (
		.clk(clk), .arst_n(arst_n), .chan(1'b0), .ctl(ctl), .stat(st_l), .acc(acc_l)
	);

	scar_lane u_lane_r (
		.clk(clk), .arst_n(arst_n), .chan(1'b1), .ctl(ctl), .stat(st_r), .acc(acc_r)
	);

	scar_merge u_merge_l (
		.clk(clk), .acc(acc_l), .wet(wet_c), .sample(l_q), .mixed_s2(lmix)
	);

	scar_merge u_merge_r (
		.clk(clk), .acc(acc_r), .wet(wet_c), .sample(r_q), .mixed_s2(rmix)
	);

	// both lanes run in lockstep
	assert property (@(posedge clk) disable iff (!arst_n) st_l == st_r)
		else $error("lanes out of step");

	// a lane finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n) st_l.done |-> state_q == T_RUN)
		else $error("lane done outside run");

	// a pending word is never replaced before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output overwritten");

	// new frames start only on idle lanes
	assert property (@(posedge clk) disable iff (!arst_n) start |-> st_l.ready)
		else $error("start while lane busy");

endmodule
